// File: rtl/core/ptrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_pkg: shared constants and functions for the point transform
// Holds the coordinate width, the CORDIC arctangent table, the gain
// constant, and the register map of the configuration port.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  // Default pipeline parameters.
  localparam int CordicStagesDef = 16;
  localparam int FracBitsDef     = 16;

  // Width of a coordinate inside the rotation chain. A 33-bit translated
  // value grows by at most about 1.65 per CORDIC pass and sqrt(3) overall,
  // so 38 bits leave ample headroom.
  localparam int CoordW = 38;

  // Scale product width: coordinate times a 17-bit signed scale.
  localparam int ScaleProdW = CoordW + 17;

  // Configuration register map.
  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegShiftX  = 3'd0;
  localparam logic [RegIdxW-1:0] RegShiftY  = 3'd1;
  localparam logic [RegIdxW-1:0] RegShiftZ  = 3'd2;
  localparam logic [RegIdxW-1:0] RegAngleX  = 3'd3;
  localparam logic [RegIdxW-1:0] RegAngleY  = 3'd4;
  localparam logic [RegIdxW-1:0] RegAngleZ  = 3'd5;
  localparam logic [RegIdxW-1:0] RegScales  = 3'd6;
  localparam logic [RegIdxW-1:0] RegMirror  = 3'd7;

  localparam logic [47:0] ScalesReset = 48'h1000_1000_1000;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] ptrs_atan(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // CORDIC gain compensation 0.60725... rounded to frac fraction bits.
  function automatic logic [63:0] ptrs_gain(input int frac);
    logic [63:0] k;
    k = (64'h9B74EDA8 + (64'd1 << (31 - frac))) >> (32 - frac);
    return k;
  endfunction

endpackage

// File: rtl/core/ptrs_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_rot: pipelined CORDIC rotation of one coordinate pair
// Folds the angle into the right half plane, runs one CORDIC iteration per
// register stage, multiplies by the gain constant and rounds. A third
// coordinate rides along unchanged.
// ----------------------------------------------------------------------------
module ptrs_rot #(
  parameter int STAGES = 16,
  parameter int FRAC   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic signed [ptrs_pkg::CoordW-1:0] a_i,
  input  logic signed [ptrs_pkg::CoordW-1:0] b_i,
  input  logic signed [ptrs_pkg::CoordW-1:0] c_i,
  input  logic [15:0]                       ang_i,
  output logic                              vld_o,
  output logic signed [ptrs_pkg::CoordW-1:0] a_o,
  output logic signed [ptrs_pkg::CoordW-1:0] b_o,
  output logic signed [ptrs_pkg::CoordW-1:0] c_o
);
  import ptrs_pkg::*;

  localparam int Lat = STAGES + 3;
  localparam int PW  = CoordW + FRAC + 2;
  localparam logic signed [PW-1:0] K = PW'(ptrs_gain(FRAC));
  localparam logic signed [PW-1:0] Half = PW'(64'd1 << (FRAC - 1));

  logic [Lat-1:0] vld_r;
  logic signed [CoordW-1:0] a_r [0:STAGES];
  logic signed [CoordW-1:0] b_r [0:STAGES];
  logic signed [32:0]       z_r [0:STAGES];
  logic signed [CoordW-1:0] c_r [0:Lat-1];
  logic signed [PW-1:0]     ma_r, mb_r;
  logic signed [CoordW-1:0] ra_r, rb_r;
  logic                     flip;
  logic [15:0]              ang_f;
  logic signed [PW-1:0]     ra_nxt, rb_nxt;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], vld_i};
    end
  end

  // Fold angles in the left half plane by a half turn.
  assign flip  = ang_i[15] ^ ang_i[14];
  assign ang_f = {ang_i[15] ^ flip, ang_i[14:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= flip ? -a_i : a_i;
      b_r[0] <= flip ? -b_i : b_i;
      z_r[0] <= {ang_f[15], ang_f, 16'h0000};
      c_r[0] <= c_i;
    end
  end

  // One CORDIC iteration per stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [32:0] Atan = 33'(ptrs_atan(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][32]) begin
          a_r[i+1] <= a_r[i] - (b_r[i] >>> i);
          b_r[i+1] <= b_r[i] + (a_r[i] >>> i);
          z_r[i+1] <= z_r[i] - Atan;
        end else begin
          a_r[i+1] <= a_r[i] + (b_r[i] >>> i);
          b_r[i+1] <= b_r[i] - (a_r[i] >>> i);
          z_r[i+1] <= z_r[i] + Atan;
        end
      end
    end
  end

  // Carry the untouched coordinate along.
  for (genvar j = 1; j < Lat; j++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        c_r[j] <= c_r[j-1];
      end
    end
  end

  // Gain compensation, then round half up.
  assign ra_nxt = (ma_r + Half) >>> FRAC;
  assign rb_nxt = (mb_r + Half) >>> FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= PW'(a_r[STAGES]) * K;
      mb_r <= PW'(b_r[STAGES]) * K;
      ra_r <= ra_nxt[CoordW-1:0];
      rb_r <= rb_nxt[CoordW-1:0];
    end
  end

  assign vld_o = vld_r[Lat-1];
  assign a_o   = ra_r;
  assign b_o   = rb_r;
  assign c_o   = c_r[Lat-1];

endmodule

// File: rtl/core/point_translate_rotate_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_translate_rotate_scale: 3D point translate, rotate and scale
// Shifts a Q16.16 point, rotates it about X, Y and Z, scales each axis
// with optional mirroring, and saturates the result to 32 bits.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle while the output is not stalled
// and passes each point through a translation register, three chained
// CORDIC rotation pipelines (each one register stage per iteration plus
// fold, gain multiply and rounding), a scale multiply register and the
// output register. A stall at the output freezes the whole pipeline. Registers
// sit on the APB-style port at byte address 8 * index, 64-bit data, and are
// to be written only while no item is in flight.
module point_translate_rotate_scale #(
  parameter int CORDIC_STAGES = ptrs_pkg::CordicStagesDef,
  parameter int FRAC_BITS     = ptrs_pkg::FracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import ptrs_pkg::*;

  localparam logic signed [ScaleProdW-1:0] SatMax = ScaleProdW'(64'sh7FFFFFFF);
  localparam logic signed [ScaleProdW-1:0] SatMin = -ScaleProdW'(64'sh80000000);

  logic signed [31:0] shift_x_r, shift_y_r, shift_z_r;
  logic [15:0]        ang_x_r, ang_y_r, ang_z_r;
  logic [47:0]        scales_r;
  logic [2:0]         mirror_r;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;
  logic               en;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
      ang_x_r   <= '0;
      ang_y_r   <= '0;
      ang_z_r   <= '0;
      scales_r  <= ScalesReset;
      mirror_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegShiftX: shift_x_r <= pwdata[31:0];
        RegShiftY: shift_y_r <= pwdata[31:0];
        RegShiftZ: shift_z_r <= pwdata[31:0];
        RegAngleX: ang_x_r   <= pwdata[15:0];
        RegAngleY: ang_y_r   <= pwdata[15:0];
        RegAngleZ: ang_z_r   <= pwdata[15:0];
        RegScales: scales_r  <= pwdata[47:0];
        RegMirror: mirror_r  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      RegShiftX: prdata = {32'h0, shift_x_r};
      RegShiftY: prdata = {32'h0, shift_y_r};
      RegShiftZ: prdata = {32'h0, shift_z_r};
      RegAngleX: prdata = {48'h0, ang_x_r};
      RegAngleY: prdata = {48'h0, ang_y_r};
      RegAngleZ: prdata = {48'h0, ang_z_r};
      RegScales: prdata = {16'h0, scales_r};
      RegMirror: prdata = {61'h0, mirror_r};
      default:   prdata = '0;
    endcase
  end

  // The whole pipeline advances unless the output holds an untaken item.
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  // Translation stage.
  logic                     t_vld_r;
  logic signed [CoordW-1:0] tx_r, ty_r, tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= CoordW'(in_x) + CoordW'(shift_x_r);
      ty_r <= CoordW'(in_y) + CoordW'(shift_y_r);
      tz_r <= CoordW'(in_z) + CoordW'(shift_z_r);
    end
  end

  // Rotation about X on (y, z), then Y on (z, x), then Z on (x, y).
  logic                     rx_vld, ry_vld, rz_vld;
  logic signed [CoordW-1:0] rx_y, rx_z, rx_x;
  logic signed [CoordW-1:0] ry_z, ry_x, ry_y;
  logic signed [CoordW-1:0] rz_x, rz_y, rz_z;

  ptrs_rot #(.STAGES(CORDIC_STAGES), .FRAC(FRAC_BITS)) u_rot_x (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(t_vld_r),
    .a_i(ty_r), .b_i(tz_r), .c_i(tx_r), .ang_i(ang_x_r),
    .vld_o(rx_vld), .a_o(rx_y), .b_o(rx_z), .c_o(rx_x)
  );

  ptrs_rot #(.STAGES(CORDIC_STAGES), .FRAC(FRAC_BITS)) u_rot_y (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(rx_vld),
    .a_i(rx_z), .b_i(rx_x), .c_i(rx_y), .ang_i(ang_y_r),
    .vld_o(ry_vld), .a_o(ry_z), .b_o(ry_x), .c_o(ry_y)
  );

  ptrs_rot #(.STAGES(CORDIC_STAGES), .FRAC(FRAC_BITS)) u_rot_z (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ry_vld),
    .a_i(ry_x), .b_i(ry_y), .c_i(ry_z), .ang_i(ang_z_r),
    .vld_o(rz_vld), .a_o(rz_x), .b_o(rz_y), .c_o(rz_z)
  );

  // Scale multiply stage; a mirror flag negates the scale at 17 bits.
  logic signed [16:0]           sc_x, sc_y, sc_z;
  logic                         m_vld_r;
  logic signed [ScaleProdW-1:0] px_r, py_r, pz_r;

  assign sc_x = mirror_r[1] ? -17'(signed'(scales_r[15:0]))  : 17'(signed'(scales_r[15:0]));
  assign sc_y = mirror_r[2] ? -17'(signed'(scales_r[31:16])) : 17'(signed'(scales_r[31:16]));
  assign sc_z = mirror_r[0] ? -17'(signed'(scales_r[47:32])) : 17'(signed'(scales_r[47:32]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= rz_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= ScaleProdW'(rz_x) * ScaleProdW'(sc_x);
      py_r <= ScaleProdW'(rz_y) * ScaleProdW'(sc_y);
      pz_r <= ScaleProdW'(rz_z) * ScaleProdW'(sc_z);
    end
  end

  // Round half up by 12 bits and saturate into the output register.
  logic signed [ScaleProdW-1:0] qx, qy, qz;
  logic                         ox, oy, oz;
  logic                         out_vld_r;
  logic signed [31:0]           out_x_r, out_y_r, out_z_r;
  logic                         out_ovf_r;

  assign qx = (px_r + ScaleProdW'(2048)) >>> 12;
  assign qy = (py_r + ScaleProdW'(2048)) >>> 12;
  assign qz = (pz_r + ScaleProdW'(2048)) >>> 12;
  assign ox = (qx > SatMax) | (qx < SatMin);
  assign oy = (qy > SatMax) | (qy < SatMin);
  assign oz = (qz > SatMax) | (qz < SatMin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= ox ? (qx[ScaleProdW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : qx[31:0];
      out_y_r   <= oy ? (qy[ScaleProdW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : qy[31:0];
      out_z_r   <= oz ? (qz[ScaleProdW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : qz[31:0];
      out_ovf_r <= ox | oy | oz;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_z        = out_z_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  // A flagged overflow shows at least one coordinate at a rail.
  a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      (out_x == 32'sh7FFFFFFF || out_x == 32'sh80000000 ||
       out_y == 32'sh7FFFFFFF || out_y == 32'sh80000000 ||
       out_z == 32'sh7FFFFFFF || out_z == 32'sh80000000))
    else $error("overflow flagged without a saturated coordinate");

  // Input backpressure only comes from a held output item.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("pipeline stalled without output backpressure");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
